// File: design/sparse_two_of_four_compressor_core_assert.svh
// Assertion macros used by the checker of the two-of-four compressor.
`ifndef SPARSE_TWO_OF_FOUR_COMPRESSOR_CORE_ASSERT_SVH
`define SPARSE_TWO_OF_FOUR_COMPRESSOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define SPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define SPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define SPC_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("check across reset failed");

`endif

// File: design/spc_pkg.sv
// Package with shared types and constants of the two-of-four compressor.
package spc_pkg;

    localparam int ELEM_W        = 16;
    localparam int ELEM_BITS_DEF = 16;
    localparam int IDX_W         = 8;
    localparam int GROUP_N       = 4;

    typedef enum logic [2:0] {
        ET_FP16 = 3'd0,
        ET_BF16 = 3'd1,
        ET_INT8 = 3'd2,
        ET_E4M3 = 3'd3,
        ET_E5M2 = 3'd4
    } t_elem_type;

    localparam logic [IDX_W-1:0] IDX_DEFAULT = 8'hEE;
    localparam logic [1:0]       POS_SLOT0_EMPTY = 2'd2;
    localparam logic [1:0]       POS_SLOT1_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0] pos1;
        logic [1:0] pos0;
    } t_group_pos;

endpackage

// File: design/spc_lane.sv
// One element lane: width masking and the zero test selected by element type.
module spc_lane #(
    parameter int ElementBits = 16
) (
    input  spc_pkg::t_elem_type     i_elem_type,
    input  logic [15:0]             i_elem,
    output logic [ElementBits-1:0]  o_value,
    output logic                    o_nonzero
);
    import spc_pkg::*;

    localparam logic [ElementBits-1:0] ByteMask = ElementBits'(16'h00FF);
    localparam logic [ElementBits-1:0] MagMask  = ElementBits'(16'h7FFF);

    logic [ElementBits-1:0] w_raw;

    assign w_raw = i_elem[ElementBits-1:0];

    always_comb begin
        unique case (i_elem_type) inside
            ET_FP16, ET_BF16: begin
                o_value   = w_raw;
                o_nonzero = |(w_raw & MagMask);
            end
            ET_INT8: begin
                o_value   = w_raw & ByteMask;
                o_nonzero = |w_raw[7:0];
            end
            ET_E4M3, ET_E5M2: begin
                o_value   = w_raw & ByteMask;
                o_nonzero = |w_raw[6:0];
            end
            default: begin
                o_value   = w_raw;
                o_nonzero = |w_raw;
            end
        endcase
    end

endmodule

// File: design/spc_group.sv
// Selection of the first two nonzero elements of one group of four.
module spc_group #(
    parameter int ElementBits = 16
) (
    input  logic [ElementBits-1:0]  i_val0,
    input  logic [ElementBits-1:0]  i_val1,
    input  logic [ElementBits-1:0]  i_val2,
    input  logic [ElementBits-1:0]  i_val3,
    input  logic [3:0]              i_nonzero,
    output logic [ElementBits-1:0]  o_slot0,
    output logic [ElementBits-1:0]  o_slot1,
    output spc_pkg::t_group_pos     o_pos
);
    import spc_pkg::*;

    always_comb begin
        o_slot0   = '0;
        o_slot1   = '0;
        o_pos.pos0 = POS_SLOT0_EMPTY;
        o_pos.pos1 = POS_SLOT1_EMPTY;
        if (i_nonzero[0]) begin
            o_slot0    = i_val0;
            o_pos.pos0 = 2'd0;
            if (i_nonzero[1]) begin
                o_slot1    = i_val1;
                o_pos.pos1 = 2'd1;
            end else if (i_nonzero[2]) begin
                o_slot1    = i_val2;
                o_pos.pos1 = 2'd2;
            end else if (i_nonzero[3]) begin
                o_slot1    = i_val3;
                o_pos.pos1 = 2'd3;
            end
        end else if (i_nonzero[1]) begin
            o_slot0    = i_val1;
            o_pos.pos0 = 2'd1;
            if (i_nonzero[2]) begin
                o_slot1    = i_val2;
                o_pos.pos1 = 2'd2;
            end else if (i_nonzero[3]) begin
                o_slot1    = i_val3;
                o_pos.pos1 = 2'd3;
            end
        end else if (i_nonzero[2]) begin
            o_slot0    = i_val2;
            o_pos.pos0 = 2'd2;
            if (i_nonzero[3]) begin
                o_slot1    = i_val3;
                o_pos.pos1 = 2'd3;
            end
        end else if (i_nonzero[3]) begin
            // A lone nonzero at the last position lands in the second slot.
            o_slot1    = i_val3;
            o_pos.pos1 = 2'd3;
        end
    end

endmodule

// File: design/sparse_two_of_four_compressor_core.sv
// Top level of the two-of-four structured sparsity compressor.
//
// Each command carries eight dense elements (two groups of four). A command
// is taken at a rising edge with start high and busy low; busy stays low, so
// one command can be issued every cycle with no gaps.
// Eight lanes run the zero test of the selected element type in parallel,
// two group selectors keep the first two nonzeros of each group, and a merge
// stage packs the four kept values and the index byte into output registers.
// o_valid pulses in the cycle after the command, and the result is taken at
// the edge that ends that cycle. Throughput is one item per cycle, set by
// the single register stage after the selectors.
// The receiver cannot stall; every result is shown exactly once.
// The element type is written through the cfg channel (always ready) and
// should be changed only while no command is in flight.
// Synchronous active-low reset clears o_valid and sets the element type to
// fp16.
module sparse_two_of_four_compressor_core #(
    parameter int ElementBits = spc_pkg::ELEM_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_elem0,
    input  logic [15:0] i_elem1,
    input  logic [15:0] i_elem2,
    input  logic [15:0] i_elem3,
    input  logic [15:0] i_elem4,
    input  logic [15:0] i_elem5,
    input  logic [15:0] i_elem6,
    input  logic [15:0] i_elem7,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data,
    output logic        o_valid,
    output logic [15:0] o_kept0,
    output logic [15:0] o_kept1,
    output logic [15:0] o_kept2,
    output logic [15:0] o_kept3,
    output logic [7:0]  o_index_byte
);
    import spc_pkg::*;

    t_elem_type             r_elem_type;
    logic                   r_valid;
    logic [ElementBits-1:0] r_kept [4];
    logic [IDX_W-1:0]       r_index;

    logic [15:0]            w_elem   [8];
    logic [ElementBits-1:0] w_value  [8];
    logic [7:0]             w_nonzero;
    logic [ElementBits-1:0] w_slot   [4];
    t_group_pos             w_pos    [2];
    logic [IDX_W-1:0]       n_index;

    assign w_elem[0] = i_elem0;
    assign w_elem[1] = i_elem1;
    assign w_elem[2] = i_elem2;
    assign w_elem[3] = i_elem3;
    assign w_elem[4] = i_elem4;
    assign w_elem[5] = i_elem5;
    assign w_elem[6] = i_elem6;
    assign w_elem[7] = i_elem7;

    for (genvar l = 0; l < 8; l++) begin : g_lane
        spc_lane #(
            .ElementBits(ElementBits)
        ) u_lane (
            .i_elem_type(r_elem_type),
            .i_elem     (w_elem[l]),
            .o_value    (w_value[l]),
            .o_nonzero  (w_nonzero[l])
        );
    end

    for (genvar g = 0; g < 2; g++) begin : g_group
        spc_group #(
            .ElementBits(ElementBits)
        ) u_group (
            .i_val0   (w_value[g*GROUP_N + 0]),
            .i_val1   (w_value[g*GROUP_N + 1]),
            .i_val2   (w_value[g*GROUP_N + 2]),
            .i_val3   (w_value[g*GROUP_N + 3]),
            .i_nonzero(w_nonzero[g*GROUP_N +: GROUP_N]),
            .o_slot0  (w_slot[g*2 + 0]),
            .o_slot1  (w_slot[g*2 + 1]),
            .o_pos    (w_pos[g])
        );
    end

    // Slot n's position sits in bits 2n+1:2n of the index byte.
    assign n_index = {w_pos[1].pos1, w_pos[1].pos0, w_pos[0].pos1, w_pos[0].pos0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_type <= ET_FP16;
            r_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_elem_type <= t_elem_type'(i_cfg_data);
            end
            r_valid <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_kept  <= w_slot;
            r_index <= n_index;
        end
    end

    assign busy         = 1'b0;
    assign o_cfg_ready  = 1'b1;
    assign o_valid      = r_valid;
    assign o_kept0      = 16'(r_kept[0]);
    assign o_kept1      = 16'(r_kept[1]);
    assign o_kept2      = 16'(r_kept[2]);
    assign o_kept3      = 16'(r_kept[3]);
    assign o_index_byte = r_index;

endmodule

// File: design/spc_checker.sv
// Port-level checker for the two-of-four compressor, bound to the top level.
`include "sparse_two_of_four_compressor_core_assert.svh"

module spc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [15:0] o_kept0,
    input logic [15:0] o_kept1,
    input logic [15:0] o_kept2,
    input logic [15:0] o_kept3,
    input logic [7:0]  o_index_byte
);

    // No result strobe in the cycle after reset.
    `SPC_ASSERT_ALWAYS_NEXT(a_reset_quiet, i_clk, !i_rst_n, !o_valid)

    // Each accepted command gives exactly one result, in the next cycle.
    `SPC_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, start && !busy, o_valid)
    `SPC_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !(start && !busy), !o_valid)

    // An empty slot carries its default position; a filled first slot never
    // holds the last position of its group.
    `SPC_ASSERT_IMPL(a_group1_slots, i_clk, i_rst_n, o_valid,
        (o_kept0 != 16'd0 || o_index_byte[1:0] == 2'd2) &&
        (o_kept1 != 16'd0 || o_index_byte[3:2] == 2'd3) &&
        (o_kept0 == 16'd0 || o_index_byte[1:0] != 2'd3))
    `SPC_ASSERT_IMPL(a_group2_slots, i_clk, i_rst_n, o_valid,
        (o_kept2 != 16'd0 || o_index_byte[5:4] == 2'd2) &&
        (o_kept3 != 16'd0 || o_index_byte[7:6] == 2'd3) &&
        (o_kept2 == 16'd0 || o_index_byte[5:4] != 2'd3))

endmodule

bind sparse_two_of_four_compressor_core spc_checker u_spc_checker (.*);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the two-of-four sparsity compressor core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spc_pkg::*;

    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int RANDOM_PER_PHASE = 120;
    localparam int NUM_PHASES       = 10;
    localparam int MAX_PRINTED      = 40;

    // Codes above the last defined element type fall back to a plain all-bits zero test.
    localparam logic [2:0] ET_SPARE5 = 3'd5;
    localparam logic [2:0] ET_SPARE6 = 3'd6;
    localparam logic [2:0] ET_SPARE7 = 3'd7;

    localparam logic [15:0] ELEM_MASK = 16'((32'd1 << ELEM_BITS_DEF) - 32'd1);

    typedef logic [7:0][15:0] t_dense;

    typedef struct packed {
        logic [3:0][15:0] kept;
        logic [IDX_W-1:0] idx;
    } t_compressed;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic        busy;
    logic [15:0] i_elem0      = '0;
    logic [15:0] i_elem1      = '0;
    logic [15:0] i_elem2      = '0;
    logic [15:0] i_elem3      = '0;
    logic [15:0] i_elem4      = '0;
    logic [15:0] i_elem5      = '0;
    logic [15:0] i_elem6      = '0;
    logic [15:0] i_elem7      = '0;
    logic        i_cfg_valid  = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_data   = '0;
    logic        o_valid;
    logic [15:0] o_kept0;
    logic [15:0] o_kept1;
    logic [15:0] o_kept2;
    logic [15:0] o_kept3;
    logic [7:0]  o_index_byte;

    t_dense      dense_q[$];
    t_compressed compressed_q[$];
    logic [2:0]  elem_type_cfg = ET_FP16;
    int          error_count   = 0;
    int          idle_cycles   = 0;
    int          burst_left    = 0;
    int          gap_left      = 0;
    logic        steady_flow   = 1'b0;
    logic        pause_req     = 1'b0;

    sparse_two_of_four_compressor_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_elem0      (i_elem0),
        .i_elem1      (i_elem1),
        .i_elem2      (i_elem2),
        .i_elem3      (i_elem3),
        .i_elem4      (i_elem4),
        .i_elem5      (i_elem5),
        .i_elem6      (i_elem6),
        .i_elem7      (i_elem7),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_kept0      (o_kept0),
        .o_kept1      (o_kept1),
        .o_kept2      (o_kept2),
        .o_kept3      (o_kept3),
        .o_index_byte (o_index_byte)
    );

    // The clock starts low so that the first rising edge comes after time zero.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Floating types ignore the sign bit so that minus zero counts as zero.
    function automatic logic is_nonzero(logic [15:0] v, logic [2:0] et);
        case (et)
            ET_FP16, ET_BF16: return v[14:0] != '0;
            ET_INT8:          return v[7:0] != '0;
            ET_E4M3, ET_E5M2: return v[6:0] != '0;
            default:          return v != '0;
        endcase
    endfunction

    function automatic t_compressed compress_groups(t_dense d, logic [2:0] et);
        t_compressed r;
        logic [15:0] wmask;
        logic [15:0] v;
        int          filled;
        int          slot;
        r.kept = '0;
        r.idx  = IDX_DEFAULT;
        wmask  = ELEM_MASK;
        if (et == ET_INT8 || et == ET_E4M3 || et == ET_E5M2) begin
            wmask &= 16'h00FF;
        end
        for (int g = 0; g < 2; g++) begin
            filled = 0;
            for (int k = 0; k < GROUP_N; k++) begin
                v = d[g * GROUP_N + k] & wmask;
                if (is_nonzero(v, et) && filled < 2) begin
                    // A lone nonzero in the last position lands in the second slot.
                    if (filled == 0 && k == GROUP_N - 1) begin
                        filled = 1;
                    end
                    slot = g * 2 + filled;
                    r.kept[slot]        = v;
                    r.idx[slot * 2 +: 2] = 2'(k);
                    filled++;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(0, 9))
            0, 1, 2: return 16'h0000;
            3:       return 16'h8000;
            4:       return {8'($urandom), 8'h00};
            5:       return {8'($urandom), 8'h80};
            6:       return 16'($urandom_range(1, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("%0t ns: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            flag_error($sformatf("%s mismatch: got %h, expected %h", name, got, want));
        end
    endtask

    task automatic add_item(input logic [15:0] e0, e1, e2, e3, e4, e5, e6, e7);
        dense_q.push_back({e7, e6, e5, e4, e3, e2, e1, e0});
    endtask

    // Waits until every queued command has been taken and every result has come.
    task automatic settle();
        do begin
            @(posedge i_clk);
        end while (dense_q.size() != 0 || compressed_q.size() != 0 || pause_req);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_elem_type(input logic [2:0] et);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= et;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) begin
            @(posedge i_clk);
        end
        elem_type_cfg = et;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Driver: presents the oldest pending command in bursts, with random gaps unless flow is steady.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (pause_req) begin
            if (compressed_q.size() == 0) begin
                pause_req = 1'b0;
            end
            start <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
        end else if (dense_q.size() > 0) begin
            {i_elem7, i_elem6, i_elem5, i_elem4,
             i_elem3, i_elem2, i_elem1, i_elem0} <= dense_q[0];
            start <= 1'b1;
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 30);
                gap_left   = steady_flow ? 0 : $urandom_range(1, 6);
            end
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: checks results against predictions, records accepted commands,
    // and ends the run if no transfer of any kind happens for too long.
    always @(posedge i_clk) begin
        t_compressed want;
        logic        moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_valid !== 1'b0) begin
                moved = 1'b1;
                if (compressed_q.size() == 0) begin
                    flag_error("result with no command outstanding");
                end else begin
                    want = compressed_q.pop_front();
                    check_field("kept0", o_kept0, want.kept[0]);
                    check_field("kept1", o_kept1, want.kept[1]);
                    check_field("kept2", o_kept2, want.kept[2]);
                    check_field("kept3", o_kept3, want.kept[3]);
                    check_field("index_byte", 16'(o_index_byte), 16'(want.idx));
                end
            end
            if (start && !busy) begin
                moved = 1'b1;
                compressed_q.push_back(compress_groups(dense_q.pop_front(), elem_type_cfg));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL sparse_two_of_four_compressor_core");
                $finish;
            end
        end
    end

    initial begin
        logic [2:0] phase_types [NUM_PHASES];
        logic [2:0] et;
        phase_types = '{ET_BF16, ET_INT8, ET_E4M3, ET_E5M2, ET_SPARE5,
                        ET_SPARE6, ET_SPARE7, ET_FP16, ET_FP16, ET_FP16};

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_elem_type(ET_FP16);
        @(posedge i_clk);
        // Empty groups, full groups, minus zeros, lone last-position values,
        // dropped third and fourth nonzeros, and NaN or infinity patterns.
        add_item(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_item(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        add_item(16'h0000, 16'h0000, 16'h0000, 16'h7C00,
                 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        add_item(16'h0000, 16'h1234, 16'h0000, 16'h0000,
                 16'h0000, 16'h0000, 16'h8001, 16'h0000);
        add_item(16'h0000, 16'h0000, 16'h7FFF, 16'h0001,
                 16'h8000, 16'h0000, 16'h8000, 16'hFFFF);
        add_item(16'h0001, 16'h0002, 16'h0003, 16'h0004,
                 16'h0000, 16'h0005, 16'h0000, 16'h0006);
        add_item(16'hFFFF, 16'h0000, 16'h0000, 16'h0001,
                 16'h0000, 16'h8001, 16'h7C01, 16'h0000);
        add_item(16'h00FF, 16'hFF00, 16'h0080, 16'h8080,
                 16'h8000, 16'h0000, 16'h8000, 16'h0000);
        add_item(16'h7C00, 16'hFC00, 16'h7E00, 16'h0000,
                 16'h0000, 16'h8000, 16'h0100, 16'h8000);
        add_item(16'h5555, 16'hAAAA, 16'h0000, 16'h0000,
                 16'hAAAA, 16'h0000, 16'h0000, 16'h5555);
        add_item(16'h0000, 16'h0000, 16'h8000, 16'h8000,
                 16'h0000, 16'h0000, 16'h0000, 16'h8000);
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            et = (p < NUM_PHASES - 2) ? phase_types[p] : 3'($urandom_range(0, 7));
            write_elem_type(et);
            steady_flow = ($urandom_range(0, 2) == 0);
            @(posedge i_clk);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                add_item(rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                         rand_elem(), rand_elem(), rand_elem(), rand_elem());
            end
            // Halfway through, hold the sender until every outstanding result is back.
            while (dense_q.size() > RANDOM_PER_PHASE / 2) begin
                @(posedge i_clk);
            end
            pause_req = 1'b1;
            settle();
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        if (error_count == 0) begin
            $display("PASS sparse_two_of_four_compressor_core");
        end else begin
            $display("FAIL sparse_two_of_four_compressor_core");
        end
        $finish;
    end

endmodule
